// File: design/fsp_pkg.sv
// Package for the format specifier parser: phase type, character codes, result type, helpers.
package fsp_pkg;

    // Parse phases
    typedef enum logic [1:0] {
        PH_FLAGS = 2'd0,
        PH_WIDTH = 2'd1,
        PH_DOTS  = 2'd2,
        PH_PREC  = 2'd3
    } t_phase;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_S    = 8'h53;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] CH_LO_C    = 8'h63;
    localparam logic [7:0] CH_LO_D    = 8'h64;
    localparam logic [7:0] CH_LO_I    = 8'h69;
    localparam logic [7:0] CH_LO_O    = 8'h6F;
    localparam logic [7:0] CH_LO_P    = 8'h70;
    localparam logic [7:0] CH_LO_S    = 8'h73;
    localparam logic [7:0] CH_LO_U    = 8'h75;
    localparam logic [7:0] CH_LO_X    = 8'h78;

    // Number bases
    localparam logic [4:0] BASE_BIN = 5'd2;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [7:0]  LEN_MAX = 8'hFF;
    localparam logic [1:0]  DOTS_MAX = 2'd2;
    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    // One result item
    typedef struct packed {
        logic        well_formed;
        logic        plus_sign;
        logic        left_justify;
        logic        alternate_form;
        logic        zero_fill;
        logic        space_sign;
        logic [15:0] field_width;
        logic [15:0] precision_value;
        logic        has_precision;
        logic [7:0]  conversion;
        logic [4:0]  number_base;
        logic [7:0]  spec_length;
    } t_fsp_result;

    function automatic logic is_flag_char(input logic [7:0] c);
        case (c) inside
            CH_SPACE, CH_HASH, CH_ZERO, CH_PLUS, CH_MINUS: is_flag_char = 1'b1;
            default: is_flag_char = 1'b0;
        endcase
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        case (c) inside
            [CH_ZERO:CH_NINE]: is_digit_char = 1'b1;
            default: is_digit_char = 1'b0;
        endcase
    endfunction

    function automatic logic is_conv_letter(input logic [7:0] c);
        case (c) inside
            CH_LO_C, CH_LO_D, CH_LO_I, CH_LO_O, CH_LO_U, CH_LO_X, CH_UP_X,
            CH_LO_P, CH_LO_B, CH_LO_S, CH_UP_S: is_conv_letter = 1'b1;
            default: is_conv_letter = 1'b0;
        endcase
    endfunction

    function automatic logic [4:0] base_of(input logic [7:0] c);
        case (c) inside
            CH_LO_X, CH_UP_X: base_of = BASE_HEX;
            CH_LO_B:          base_of = BASE_BIN;
            CH_LO_O:          base_of = BASE_OCT;
            default:          base_of = BASE_DEC;
        endcase
    endfunction

    // Clamp an accumulator (zero-extended to 32 bits) to the 16-bit field range
    function automatic logic [15:0] clamp16(input logic [31:0] v);
        clamp16 = (v > 32'(FIELD_MAX)) ? FIELD_MAX : v[15:0];
    endfunction

endpackage

// File: design/fsp_dec_acc.sv
// Saturating decimal accumulator step: acc * 10 + digit.
module fsp_dec_acc #(
    parameter int NUMBER_BITS = 16
) (
    input  logic [NUMBER_BITS-1:0] i_acc,
    input  logic [3:0]             i_digit,
    output logic [NUMBER_BITS-1:0] o_acc
);
    logic [NUMBER_BITS+3:0] sum;

    // times ten as shift-and-add, then saturate on any carry out of the range
    always_comb begin
        sum = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + (NUMBER_BITS+4)'(i_digit);
        if (sum[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
            o_acc = '1;
        end else begin
            o_acc = sum[NUMBER_BITS-1:0];
        end
    end
endmodule

// File: design/fsp_core.sv
// Parse state and per-character phase update, with the result of a terminating character.
module fsp_core #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_char,
    input  logic                 i_start,
    output logic                 o_term,
    output fsp_pkg::t_fsp_result o_res
);
    import fsp_pkg::*;

    t_phase                 r_phase, n_phase, e_phase;
    logic                   r_plus, n_plus, e_plus;
    logic                   r_minus, n_minus, e_minus;
    logic                   r_hash, n_hash, e_hash;
    logic                   r_zero, n_zero, e_zero;
    logic                   r_lfso, n_lfso, e_lfso;
    logic                   r_space, n_space, e_space;
    logic [NUMBER_BITS-1:0] r_width, n_width, e_width;
    logic [NUMBER_BITS-1:0] r_prec, n_prec, e_prec;
    logic [1:0]             r_dots, n_dots, e_dots;
    logic [7:0]             r_len, n_len, e_len;
    logic [NUMBER_BITS-1:0] width_step, prec_step;
    t_phase                 ph;
    logic                   sp;
    logic                   ok;

    fsp_dec_acc #(.NUMBER_BITS(NUMBER_BITS)) u_width_acc (
        .i_acc(e_width), .i_digit(i_char[3:0]), .o_acc(width_step)
    );
    fsp_dec_acc #(.NUMBER_BITS(NUMBER_BITS)) u_prec_acc (
        .i_acc(e_prec), .i_digit(i_char[3:0]), .o_acc(prec_step)
    );

    // state seen by this item: cleared first when it starts a specifier
    always_comb begin
        e_phase = i_start ? PH_FLAGS : r_phase;
        e_plus  = i_start ? 1'b0 : r_plus;
        e_minus = i_start ? 1'b0 : r_minus;
        e_hash  = i_start ? 1'b0 : r_hash;
        e_zero  = i_start ? 1'b0 : r_zero;
        e_lfso  = i_start ? 1'b0 : r_lfso;
        e_space = i_start ? 1'b0 : r_space;
        e_width = i_start ? '0 : r_width;
        e_prec  = i_start ? '0 : r_prec;
        e_dots  = i_start ? 2'd0 : r_dots;
        e_len   = i_start ? 8'd0 : r_len;
    end

    // phase update and result
    always_comb begin
        n_phase = e_phase;
        n_plus  = e_plus;
        n_minus = e_minus;
        n_hash  = e_hash;
        n_zero  = e_zero;
        n_lfso  = e_lfso;
        n_space = e_space;
        n_width = e_width;
        n_prec  = e_prec;
        n_dots  = e_dots;
        n_len   = (e_len != LEN_MAX) ? e_len + 8'd1 : e_len;
        o_term  = 1'b0;
        ph      = e_phase;
        sp      = e_space;
        ok      = 1'b0;

        // malformed result by default
        o_res             = '0;
        o_res.number_base = BASE_DEC;

        if (e_phase == PH_FLAGS && is_flag_char(i_char)) begin
            n_plus  = e_plus  | (i_char == CH_PLUS);
            n_minus = e_minus | (i_char == CH_MINUS);
            n_hash  = e_hash  | (i_char == CH_HASH);
            if (n_minus) begin
                n_zero = 1'b0;
            end else if (i_char == CH_ZERO) begin
                n_zero = 1'b1;
            end
            n_lfso = (i_char == CH_SPACE) && !n_minus && !n_plus && !n_hash;
        end else begin
            // leaving the flag phase fixes the space flag
            if (e_phase == PH_FLAGS) begin
                ph = PH_WIDTH;
                sp = e_lfso && is_conv_letter(i_char);
            end
            n_phase = ph;
            n_space = sp;
            if (ph == PH_WIDTH && is_digit_char(i_char)) begin
                n_width = width_step;
            end else if ((ph == PH_WIDTH || ph == PH_DOTS) && i_char == CH_DOT) begin
                n_dots  = (e_dots != DOTS_MAX) ? e_dots + 2'd1 : e_dots;
                n_phase = PH_DOTS;
            end else if (is_digit_char(i_char)) begin
                n_prec  = prec_step;
                n_phase = PH_PREC;
            end else begin
                o_term = 1'b1;
                ok = (e_dots != DOTS_MAX) &&
                     (i_char == CH_PERCENT || is_conv_letter(i_char));
                if (ok) begin
                    o_res.well_formed     = 1'b1;
                    o_res.plus_sign       = e_plus;
                    o_res.left_justify    = e_minus;
                    o_res.alternate_form  = e_hash;
                    o_res.zero_fill       = e_zero;
                    o_res.space_sign      = sp;
                    o_res.field_width     = clamp16(32'(e_width));
                    o_res.precision_value = clamp16(32'(e_prec));
                    o_res.has_precision   = (e_dots == 2'd1);
                    o_res.conversion      = i_char;
                    o_res.number_base     = base_of(i_char);
                    o_res.spec_length     = n_len;
                end
                // back to the cleared state
                n_phase = PH_FLAGS;
                n_plus  = 1'b0;
                n_minus = 1'b0;
                n_hash  = 1'b0;
                n_zero  = 1'b0;
                n_lfso  = 1'b0;
                n_space = 1'b0;
                n_width = '0;
                n_prec  = '0;
                n_dots  = 2'd0;
                n_len   = 8'd0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS;
            r_plus  <= 1'b0;
            r_minus <= 1'b0;
            r_hash  <= 1'b0;
            r_zero  <= 1'b0;
            r_lfso  <= 1'b0;
            r_space <= 1'b0;
            r_width <= '0;
            r_prec  <= '0;
            r_dots  <= 2'd0;
            r_len   <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_plus  <= n_plus;
            r_minus <= n_minus;
            r_hash  <= n_hash;
            r_zero  <= n_zero;
            r_lfso  <= n_lfso;
            r_space <= n_space;
            r_width <= n_width;
            r_prec  <= n_prec;
            r_dots  <= n_dots;
            r_len   <= n_len;
        end
    end
endmodule

// File: design/format_specifier_parser_unit.sv
// Top level of the format specifier parser: input register, parse core, result register.
//
// Takes the bytes after a percent sign, one item per clock cycle, and gives one result item
// for each byte that ends a specifier. An accepted item is parsed from the input register
// by the parse core, and its result is loaded into the result register when the item
// leaves the input register; the result register drives the master side. The
// input side stalls only when a terminating byte meets a result register that is still
// full and not being taken; otherwise a new item is taken every cycle.
// NUMBER_BITS sets the width of the width and precision accumulators, which saturate at
// 2^NUMBER_BITS-1 and are clamped again to 16 bits on output.
module format_specifier_parser_unit #(
    parameter int NUMBER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    input  logic        i_s_tuser,   // [0] spec_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [0] plus_sign, [1] left_justify, [2] alternate_form,
                                     // [3] zero_fill, [4] space_sign, [20:5] field_width,
                                     // [36:21] precision_value, [37] has_precision,
                                     // [45:38] conversion, [50:46] number_base,
                                     // [58:51] spec_length, [63:59] zero
    output logic        o_m_tuser    // [0] well_formed
);
    import fsp_pkg::*;

    logic        r_s1_vld;
    logic [7:0]  r_s1_char;
    logic        r_s1_start;
    logic        r_o_vld;
    t_fsp_result r_o_res;
    t_fsp_result core_res;
    logic        core_term;
    logic        out_free;
    logic        s1_fire;

    fsp_core #(.NUMBER_BITS(NUMBER_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_char  (r_s1_char),
        .i_start (r_s1_start),
        .o_term  (core_term),
        .o_res   (core_res)
    );

    // handshake: only a terminating item needs room in the result register
    assign out_free   = !r_o_vld || i_m_tready;
    assign s1_fire    = r_s1_vld && (!core_term || out_free);
    assign o_s_tready = !r_s1_vld || s1_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_char  <= i_s_tdata;
            r_s1_start <= i_s_tuser;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= s1_fire && core_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_fire && core_term) begin
            r_o_res <= core_res;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tuser  = r_o_res.well_formed;
    assign o_m_tdata  = {5'b00000,
                         r_o_res.spec_length,
                         r_o_res.number_base,
                         r_o_res.conversion,
                         r_o_res.has_precision,
                         r_o_res.precision_value,
                         r_o_res.field_width,
                         r_o_res.space_sign,
                         r_o_res.zero_fill,
                         r_o_res.alternate_form,
                         r_o_res.left_justify,
                         r_o_res.plus_sign};
endmodule

// File: design/fsp_checker.sv
// Port-level checker for the format specifier parser, bound to the top level.
module fsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);
    import fsp_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result item changed while stalled");

    // malformed items carry only base ten
    a_malformed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |->
            o_m_tdata[45:0] == 46'd0 && o_m_tdata[50:46] == BASE_DEC &&
            o_m_tdata[63:51] == 13'd0)
        else $error("malformed item carries field data");

    // well-formed items: legal base and a nonzero length
    a_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[50:46] == BASE_BIN || o_m_tdata[50:46] == BASE_OCT ||
             o_m_tdata[50:46] == BASE_DEC || o_m_tdata[50:46] == BASE_HEX) &&
            o_m_tdata[58:51] != 8'd0 && o_m_tdata[63:59] == 5'd0)
        else $error("bad base or length in well-formed item");

    // left justify cancels zero fill
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[1] && o_m_tdata[3]))
        else $error("zero fill together with left justify");

    // nothing is shown straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
endmodule

bind format_specifier_parser_unit fsp_checker u_fsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
